@@ rtl/core/mbe_pkg.sv @@
// shared types, constants and saturation helper for the escape-time unit
package mbe_pkg;

  localparam int MaxSide   = 4096;
  localparam int ColW      = 12;
  localparam int LimitW    = 16;
  localparam int CountW    = 17;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 32;
  localparam int StepW     = 31;
  localparam int ProdW     = ColW + StepW;
  localparam int WideW     = 48;
  localparam int QDepth    = 2;
  localparam int QPtrW     = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW     = $clog2(QDepth + 1);

  localparam logic [CfgIdxW-1:0] RegOriginRe = 3'd0;
  localparam logic [CfgIdxW-1:0] RegOriginIm = 3'd1;
  localparam logic [CfgIdxW-1:0] RegStepRe   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegStepIm   = 3'd3;
  localparam logic [CfgIdxW-1:0] RegIterLim  = 3'd4;

  localparam logic signed [31:0] ResetOriginRe = -32'sd805306368;
  localparam logic signed [31:0] ResetOriginIm = -32'sd268435456;
  localparam logic [StepW-1:0]   ResetStep     = 31'd524288;
  localparam logic [LimitW-1:0]  ResetLimit    = 16'd200;

  // 4.0 in q4.28
  localparam logic signed [32:0] EscapeBound = 33'sh040000000;

  typedef struct packed {
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic [StepW-1:0]   step_re;
    logic [StepW-1:0]   step_im;
    logic [LimitW-1:0]  iter_limit;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } coord_t;

  function automatic logic signed [31:0] sat32(input logic signed [WideW-1:0] v);
    logic signed [31:0] r;
    if (v[WideW-1:31] == '0 || v[WideW-1:31] == '1) begin
      r = v[31:0];
    end else if (v[WideW-1]) begin
      r = 32'sh80000000;
    end else begin
      r = 32'sh7fffffff;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/mbe_cfg.sv @@
// configuration register file of the escape-time unit
module mbe_cfg (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [mbe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mbe_pkg::CfgDataW-1:0] cfg_data,
  output mbe_pkg::cfg_t                cfg
);
  import mbe_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_re  <= ResetOriginRe;
      cfg.origin_im  <= ResetOriginIm;
      cfg.step_re    <= ResetStep;
      cfg.step_im    <= ResetStep;
      cfg.iter_limit <= ResetLimit;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegOriginRe: cfg.origin_re  <= cfg_data;
        RegOriginIm: cfg.origin_im  <= cfg_data;
        RegStepRe:   cfg.step_re    <= cfg_data[StepW-1:0];
        RegStepIm:   cfg.step_im    <= cfg_data[StepW-1:0];
        RegIterLim:  cfg.iter_limit <= cfg_data[LimitW-1:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/core/mbe_front.sv @@
// front end: takes a pixel and maps it to the complex point c
module mbe_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [mbe_pkg::ColW-1:0]  pixel_col,
  input  logic [mbe_pkg::ColW-1:0]  pixel_row,
  input  mbe_pkg::cfg_t             cfg,
  input  logic                      q_full,
  output logic                      push,
  output mbe_pkg::coord_t           push_data
);
  import mbe_pkg::*;

  logic             s1_valid;
  logic [ProdW-1:0] prod_re;
  logic [ProdW-1:0] prod_im;
  logic [ColW-1:0]  col_c;
  logic [ColW-1:0]  row_c;
  logic [WideW-1:0] sum_re;
  logic [WideW-1:0] sum_im;
  logic             accept;

  assign busy   = s1_valid | q_full;
  assign accept = start & ~busy;

  // index clamp to the image side
  always_comb begin
    col_c = pixel_col;
    row_c = pixel_row;
    if ({5'b0, pixel_col} > 17'(MaxSide - 1)) col_c = ColW'(MaxSide - 1);
    if ({5'b0, pixel_row} > 17'(MaxSide - 1)) row_c = ColW'(MaxSide - 1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      prod_re <= ProdW'(col_c) * ProdW'(cfg.step_re);
      prod_im <= ProdW'(row_c) * ProdW'(cfg.step_im);
    end
  end

  assign sum_re = {{(WideW-32){cfg.origin_re[31]}}, cfg.origin_re}
                + {{(WideW-ProdW){1'b0}}, prod_re};
  assign sum_im = {{(WideW-32){cfg.origin_im[31]}}, cfg.origin_im}
                + {{(WideW-ProdW){1'b0}}, prod_im};

  assign push         = s1_valid;
  assign push_data.re = sat32(signed'(sum_re));
  assign push_data.im = sat32(signed'(sum_im));

endmodule

@@ rtl/core/mbe_queue.sv @@
// short fifo of mapped points between front and back
module mbe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mbe_pkg::coord_t push_data,
  input  logic            pop,
  output logic            full,
  output logic            valid,
  output mbe_pkg::coord_t head
);
  import mbe_pkg::*;

  coord_t           slots [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QCntW-1:0] count;

  assign full  = (count == QCntW'(QDepth));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> valid)
    else $error("queue read while empty");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= QCntW'(QDepth))
    else $error("queue count out of range");
`endif

endmodule

@@ rtl/core/mbe_back.sv @@
// back end: iterates z = z*z + c and reports the escape count
module mbe_back (
  input  logic                         clk,
  input  logic                         rst,
  input  mbe_pkg::cfg_t                cfg,
  input  logic                         q_valid,
  input  mbe_pkg::coord_t              q_head,
  output logic                         pop,
  output logic                         done,
  output logic [mbe_pkg::CountW-1:0]   escape_count,
  output logic                         is_inside
);
  import mbe_pkg::*;

  typedef enum logic [1:0] {IDLE, MUL, UPD} state_t;

  state_t             state;
  coord_t             c;
  logic signed [31:0] zr;
  logic signed [31:0] zi;
  logic signed [63:0] p_rr;
  logic signed [63:0] p_ii;
  logic signed [63:0] p_ri;
  logic [CountW-1:0]  count;

  logic signed [31:0] sq_rr;
  logic signed [31:0] sq_ii;
  logic signed [32:0] mag;
  logic [CountW-1:0]  limit_ext;
  logic               keep_going;
  logic signed [31:0] zi_next;
  logic signed [31:0] zr_next;

  assign limit_ext = {1'b0, cfg.iter_limit};
  assign pop       = (state == IDLE) && q_valid;

  // squares of the current z, scaled back to q4.28 by a floor shift
  assign sq_rr = sat32({{(WideW-36){p_rr[63]}}, p_rr[63:28]});
  assign sq_ii = sat32({{(WideW-36){p_ii[63]}}, p_ii[63:28]});
  assign mag   = {sq_rr[31], sq_rr} + {sq_ii[31], sq_ii};
  assign keep_going = (count <= limit_ext) && (mag <= EscapeBound);

  // doubled cross term uses a shift of 27
  assign zi_next = sat32({{(WideW-37){p_ri[63]}}, p_ri[63:27]}
                       + {{(WideW-32){c.im[31]}}, c.im});
  assign zr_next = sat32({{(WideW-32){sq_rr[31]}}, sq_rr}
                       - {{(WideW-32){sq_ii[31]}}, sq_ii}
                       + {{(WideW-32){c.re[31]}}, c.re});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (q_valid) begin
            c     <= q_head;
            zr    <= '0;
            zi    <= '0;
            count <= '0;
            state <= MUL;
          end
        end
        MUL: begin
          p_rr  <= zr * zr;
          p_ii  <= zi * zi;
          p_ri  <= zr * zi;
          state <= UPD;
        end
        UPD: begin
          if (keep_going) begin
            zr    <= zr_next;
            zi    <= zi_next;
            count <= count + 1'b1;
            state <= MUL;
          end else begin
            done         <= 1'b1;
            escape_count <= count;
            is_inside    <= (count == limit_ext + 1'b1);
            state        <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state != IDLE) |-> (count <= limit_ext + 1'b1))
    else $error("iteration count ran past limit plus one");
  a_done_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> (escape_count <= limit_ext + 1'b1))
    else $error("reported count beyond limit plus one");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |-> state == IDLE)
    else $error("result strobe while still iterating");
  a_pop_only_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state == MUL)
    else $error("popped item did not start iterating");
`endif

endmodule

@@ rtl/core/mandelbrot_escape_time_unit.sv @@
// top level of the mandelbrot escape-time unit
// usage:
//   a pixel (pixel_col, pixel_row) is taken at a clock edge with start high
//   and busy low. the point c = origin + index * step is formed in the front
//   end (multiply, then add and saturate) and placed in a two-entry queue.
//   the back end pops one point at a time and iterates z = z*z + c.
//   each iteration passes the MUL state, which forms the three 32x32
//   products, then the UPD state: scaling, the escape test and the update of z.
//   a result pulses done for one cycle with escape_count and is_inside; the
//   receiver must take it then.
//   with the back end free, a pixel passes the front-end product register,
//   the queue and the IDLE, MUL and UPD states before done rises; the back
//   end pops the next point only in IDLE, so its iteration loop sets the throughput.
//   busy is high while the front end holds a product or the queue is full.
//   configuration: cfg_we writes cfg_data into the register cfg_index
//   (0 origin_re, 1 origin_im, 2 step_re, 3 step_im, 4 iter_limit);
//   other indexes are ignored. write only while the unit is idle.
//   reset (rst, synchronous) empties the queue, stops any iteration and
//   restores the register defaults.
module mandelbrot_escape_time_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [mbe_pkg::ColW-1:0]     pixel_col,
  input  logic [mbe_pkg::ColW-1:0]     pixel_row,
  output logic                         done,
  output logic [mbe_pkg::CountW-1:0]   escape_count,
  output logic                         is_inside,
  input  logic                         cfg_we,
  input  logic [mbe_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [mbe_pkg::CfgDataW-1:0] cfg_data
);
  import mbe_pkg::*;

  cfg_t   cfg;
  logic   q_full;
  logic   q_valid;
  logic   push;
  logic   pop;
  coord_t push_data;
  coord_t q_head;

  mbe_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mbe_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .pixel_col (pixel_col),
    .pixel_row (pixel_row),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  mbe_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .full      (q_full),
    .valid     (q_valid),
    .head      (q_head)
  );

  mbe_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .pop          (pop),
    .done         (done),
    .escape_count (escape_count),
    .is_inside    (is_inside)
  );

endmodule

@@ verif/testbench.sv @@
// self-checking testbench for the mandelbrot escape-time unit
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mbe_pkg::*;

  localparam int FracBits = 28;
  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;
  localparam int RandomPixels = 1250;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [CountW-1:0] iters;
    logic              in_set;
  } escape_t;

  typedef enum logic [1:0] {RowWrite, RowPixel, RowKnown} row_kind_e;

  typedef struct packed {
    row_kind_e          kind;
    logic [CfgIdxW-1:0] idx;
    logic [31:0]        data;
    logic [ColW-1:0]    col;
    logic [ColW-1:0]    row;
    logic [CountW-1:0]  iters;
    logic               in_set;
  } plan_row_t;

  // defaults: c = -3 - 1i at pixel (0,0), 1/512 per pixel, so (1536,512) is c = 0
  localparam plan_row_t Plan [36] = '{
    '{RowKnown, RegOriginRe, 32'h0,        12'd0,    12'd0,    17'd1,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd1536, 12'd512,  17'd201,   1'b1},
    '{RowKnown, RegOriginRe, 32'h0,        12'd4095, 12'd4095, 17'd1,     1'b0},
    '{RowPixel, RegOriginRe, 32'h0,        12'd4095, 12'd0,    17'd0,     1'b0},
    '{RowPixel, RegOriginRe, 32'h0,        12'd0,    12'd4095, 17'd0,     1'b0},
    '{RowPixel, RegOriginRe, 32'h0,        12'd1000, 12'd300,  17'd0,     1'b0},
    '{RowWrite, RegSpareLo,  32'h0,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegSpareHi,  32'hffffffff, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd1536, 12'd512,  17'd201,   1'b1},
    '{RowWrite, RegIterLim,  32'h5a5a0000, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd1536, 12'd512,  17'd1,     1'b1},
    // escapes on its only allowed pass, still reported inside
    '{RowKnown, RegOriginRe, 32'h0,        12'd0,    12'd0,    17'd1,     1'b1},
    '{RowWrite, RegIterLim,  32'h0000ffff, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd1536, 12'd512,  17'd65536, 1'b1},
    '{RowKnown, RegOriginRe, 32'h0,        12'd0,    12'd0,    17'd1,     1'b0},
    // offsets that saturate c
    '{RowWrite, RegOriginRe, 32'h7fffffff, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegOriginIm, 32'h80000000, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegStepRe,   32'hffffffff, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegStepIm,   32'hffffffff, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegIterLim,  32'd3,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowPixel, RegOriginRe, 32'h0,        12'd4095, 12'd4095, 17'd0,     1'b0},
    '{RowPixel, RegOriginRe, 32'h0,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowPixel, RegOriginRe, 32'h0,        12'd1,    12'd1,    17'd0,     1'b0},
    '{RowWrite, RegOriginRe, 32'h80000000, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegOriginIm, 32'h0,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegStepRe,   32'h0,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegStepIm,   32'h0,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd4095, 12'd4095, 17'd1,     1'b0},
    // c = -2 keeps |z|^2 exactly at the bound
    '{RowWrite, RegOriginRe, 32'he0000000, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegIterLim,  32'd10,       12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd7,    12'd9,    17'd11,    1'b1},
    // c = 1 escapes on the third pass
    '{RowWrite, RegOriginRe, 32'h10000000, 12'd0,    12'd0,    17'd0,     1'b0},
    '{RowWrite, RegIterLim,  32'd2,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd0,    12'd0,    17'd3,     1'b1},
    '{RowWrite, RegIterLim,  32'd3,        12'd0,    12'd0,    17'd0,     1'b0},
    '{RowKnown, RegOriginRe, 32'h0,        12'd0,    12'd0,    17'd3,     1'b0}
  };

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [ColW-1:0]     pixel_col = '0;
  logic [ColW-1:0]     pixel_row = '0;
  logic                done;
  logic [CountW-1:0]   escape_count;
  logic                is_inside;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // copy of the register file as the unit should hold it
  logic signed [31:0] view_re;
  logic signed [31:0] view_im;
  logic [StepW-1:0]   pitch_re;
  logic [StepW-1:0]   pitch_im;
  logic [LimitW-1:0]  max_iters;

  escape_t pending_escapes[$];
  int      mismatch_count = 0;
  int      random_sent = 0;
  bit      held_once = 1'b0;

  mandelbrot_escape_time_unit i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .pixel_col    (pixel_col),
    .pixel_row    (pixel_row),
    .done         (done),
    .escape_count (escape_count),
    .is_inside    (is_inside),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint clip32(input longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  function automatic escape_t escape_time(input logic [ColW-1:0] col,
                                          input logic [ColW-1:0] row);
    longint  cre;
    longint  cim;
    longint  zr;
    longint  zi;
    longint  zr2;
    longint  zi2;
    longint  nzi;
    int      n;
    escape_t res;
    cre = clip32(longint'(view_re) + longint'(col) * longint'(pitch_re));
    cim = clip32(longint'(view_im) + longint'(row) * longint'(pitch_im));
    zr = 0;
    zi = 0;
    zr2 = 0;
    zi2 = 0;
    n = 0;
    while (n <= int'(max_iters) && zr2 + zi2 <= longint'(EscapeBound)) begin
      // doubled cross term: shift one less
      nzi = clip32(((zr * zi) >>> (FracBits - 1)) + cim);
      zr = clip32(zr2 - zi2 + cre);
      zi = nzi;
      zr2 = clip32((zr * zr) >>> FracBits);
      zi2 = clip32((zi * zi) >>> FracBits);
      n++;
    end
    res.iters = n[CountW-1:0];
    res.in_set = (n == int'(max_iters) + 1);
    return res;
  endfunction

  task automatic flag_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 50) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  always @(negedge clk) begin : check_results
    escape_t want;
    if (!rst && done) begin
      if (pending_escapes.size() == 0) begin
        flag_mismatch($sformatf("result with no pixel pending, count %0d", escape_count));
      end else begin
        want = pending_escapes.pop_front();
        if (escape_count !== want.iters)
          flag_mismatch($sformatf("escape_count %0d, want %0d", escape_count, want.iters));
        if (is_inside !== want.in_set)
          flag_mismatch($sformatf("is_inside %b, want %b (count %0d)",
                                  is_inside, want.in_set, want.iters));
      end
    end
  end

  // start low, wait for every outstanding result, then let the unit settle
  task automatic drain_results();
    start <= 1'b0;
    while (pending_escapes.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      RegOriginRe: view_re = data;
      RegOriginIm: view_im = data;
      RegStepRe:   pitch_re = data[StepW-1:0];
      RegStepIm:   pitch_im = data[StepW-1:0];
      RegIterLim:  max_iters = data[LimitW-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [ColW-1:0] col, input logic [ColW-1:0] row,
                            input bit known, input escape_t known_res);
    start <= 1'b1;
    pixel_col <= col;
    pixel_row <= row;
    do @(negedge clk); while (busy);
    @(posedge clk);
    pending_escapes.push_back(known ? known_res : escape_time(col, row));
  endtask

  task automatic idle_between(input bit quiet);
    int r;
    int g;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) g = 0;
    else if (r < 90) g = $urandom_range(1, 4);
    else g = $urandom_range(12, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic pick_view();
    logic [31:0] ore;
    logic [31:0] oim;
    logic [31:0] sre;
    logic [31:0] sim;
    int          lim;
    int          r;
    if ($urandom_range(0, 3) == 0) begin
      // arbitrary values, mostly saturated or instant escapes
      ore = $urandom;
      oim = $urandom;
      sre = $urandom;
      sim = $urandom;
    end else begin
      // a window around the set, bit 31 of the steps is junk
      ore = 32'(-671088640 + int'($urandom_range(0, 402653184)));
      oim = 32'(-402653184 + int'($urandom_range(0, 268435456)));
      sre = {$urandom_range(0, 1) == 1, 31'($urandom_range(4096, 262144))};
      sim = {$urandom_range(0, 1) == 1, 31'($urandom_range(4096, 262144))};
    end
    r = $urandom_range(0, 99);
    if (r < 65) lim = $urandom_range(0, 40);
    else if (r < 90) lim = $urandom_range(41, 255);
    else lim = $urandom_range(256, 600);
    drain_results();
    if ($urandom_range(0, 4) == 0) write_reg(RegSpareLo + 3'($urandom_range(0, 2)), $urandom);
    write_reg(RegOriginRe, ore);
    write_reg(RegOriginIm, oim);
    write_reg(RegStepRe, sre);
    write_reg(RegStepIm, sim);
    write_reg(RegIterLim, {16'($urandom), 16'(lim)});
  endtask

  initial begin : main
    int n_items;
    bit quiet;
    view_re = ResetOriginRe;
    view_im = ResetOriginIm;
    pitch_re = ResetStep;
    pitch_im = ResetStep;
    max_iters = ResetLimit;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (Plan[i]) begin
      if (Plan[i].kind == RowWrite) begin
        drain_results();
        write_reg(Plan[i].idx, Plan[i].data);
      end else begin
        send_pixel(Plan[i].col, Plan[i].row, Plan[i].kind == RowKnown,
                   '{iters: Plan[i].iters, in_set: Plan[i].in_set});
        if (i + 1 < $size(Plan) && Plan[i + 1].kind != RowWrite) idle_between(1'b0);
      end
    end

    while (random_sent < RandomPixels) begin
      pick_view();
      n_items = (max_iters > 40) ? $urandom_range(5, 25) : $urandom_range(20, 80);
      quiet = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n_items; k++) begin
        if (k > 0) begin
          // the first time, and now and then after, hold off until the unit has emptied; else wait a random gap
          if (!held_once || $urandom_range(0, 59) == 0) begin
            held_once = 1'b1;
            drain_results();
          end else begin
            idle_between(quiet);
          end
        end
        send_pixel(ColW'($urandom_range(0, MaxSide - 1)),
                   ColW'($urandom_range(0, MaxSide - 1)), 1'b0, '0);
        random_sent++;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(70_000_000);
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
